>>> design/bsp_pl_pkg.sv
`timescale 1ns / 1ps

package bsp_pl_pkg;

  localparam int unsigned ApbAw = 3;
  localparam int unsigned ApbDw = 32;
  localparam int unsigned NodeCountW = 13;
  localparam int unsigned LinkW = 16;
  localparam int unsigned LeafW = 15;

  // Input item function codes
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_LOCATE = 1'b1;

  // Register indexes (word address)
  localparam logic [ApbAw-3:0] REG_NODE_COUNT = '0;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] dx;
    logic signed [15:0] dy;
  } line_t;

  typedef struct packed {
    logic [LinkW-1:0] c1;
    logic [LinkW-1:0] c0;
  } child_t;

  // Sequencer controls for the side-test unit
  typedef struct packed {
    logic load_off;
    logic mul_en;
    logic mul_rhs;
  } side_ctl_t;

endpackage

>>> design/bsp_pl_if.sv
`timescale 1ns / 1ps

interface bsp_pl_in_if import bsp_pl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               func;
  logic [11:0]        node_index;
  logic signed [15:0] line_x;
  logic signed [15:0] line_y;
  logic signed [15:0] line_dx;
  logic signed [15:0] line_dy;
  logic [LinkW-1:0]   child_zero;
  logic [LinkW-1:0]   child_one;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;

  modport source (
    output valid, func, node_index, line_x, line_y, line_dx, line_dy,
           child_zero, child_one, point_x, point_y,
    input  ready
  );
  modport sink (
    input  valid, func, node_index, line_x, line_y, line_dx, line_dy,
           child_zero, child_one, point_x, point_y,
    output ready
  );
endinterface

interface bsp_pl_out_if import bsp_pl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LeafW-1:0] leaf_index;
  logic             walk_error;

  modport source (output valid, leaf_index, walk_error, input ready);
  modport sink (input valid, leaf_index, walk_error, output ready);
endinterface

>>> design/bsp_pl_side.sv
`timescale 1ns / 1ps

module bsp_pl_side import bsp_pl_pkg::*; (
  input  logic               clk_i,
  input  side_ctl_t          ctl_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  line_t              line_i,
  output logic               side_o
);

  logic signed [32:0] ox_q, oy_q;
  logic signed [32:0] ox_d, oy_d;
  logic signed [15:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [48:0] prod;
  logic signed [48:0] lhs_q, rhs_q;

  // Offsets from the line origin, origin scaled to 16.16
  assign ox_d = $signed({point_x_i[31], point_x_i})
              - $signed({line_i.x[15], line_i.x, 16'h0000});
  assign oy_d = $signed({point_y_i[31], point_y_i})
              - $signed({line_i.y[15], line_i.y, 16'h0000});

  // Shared multiplier: dy*ox first, then dx*oy
  assign mul_a = ctl_i.mul_rhs ? line_i.dx : line_i.dy;
  assign mul_b = ctl_i.mul_rhs ? oy_q : ox_q;
  assign prod  = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load_off) begin
      ox_q <= ox_d;
      oy_q <= oy_d;
    end
    if (ctl_i.mul_en) begin
      if (ctl_i.mul_rhs) begin
        rhs_q <= prod;
      end else begin
        lhs_q <= prod;
      end
    end
  end

  assign side_o = (rhs_q < lhs_q) ? 1'b0 : 1'b1;

endmodule

>>> design/bsp_point_location_core.sv
`timescale 1ns / 1ps

// BSP point location. Write words load one node entry (line origin, direction and two child
// links, bit 15 of a link marking a leaf). A locate word walks from the root, node
// node_count-1, and returns one result word with the leaf index, or leaf 0 with walk_error set
// when the walk meets an index not below node_count or not below MAX_NODES, or visits MAX_DEPTH
// nodes without reaching a leaf; with node_count zero it answers leaf 0. Each visited node costs
// a registered node memory read, an offset step and two passes through the single 16x33
// multiplier, then the compare and child select; a walk that fails on an unloaded index or the
// depth bound stops at the read step. Input is not ready until the walk finishes and its result
// has entered the output register; the result sits there so the next word can be taken while it
// waits. node_count is an APB register at address 0.
module bsp_point_location_core import bsp_pl_pkg::*; #(
  parameter int unsigned MAX_NODES = 4096,
  parameter int unsigned MAX_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  bsp_pl_in_if.sink            in_i,
  bsp_pl_out_if.source         out_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [ApbAw-1:0]     paddr,
  input  logic [ApbDw-1:0]     pwdata,
  output logic [ApbDw-1:0]     prdata,
  output logic                 pready
);

  localparam int unsigned IdxW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int unsigned DepW = $clog2(MAX_DEPTH + 1);
  localparam logic [15:0] MaxNodesW = 16'(MAX_NODES);
  localparam logic [DepW-1:0] MaxDepthW = DepW'(MAX_DEPTH);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_OFFSET = 3'd2;
  localparam logic [2:0] S_MUL_L  = 3'd3;
  localparam logic [2:0] S_MUL_R  = 3'd4;
  localparam logic [2:0] S_DECIDE = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0]            state_q, state_d;
  logic [NodeCountW-1:0] node_count_q;
  logic [LeafW-1:0]      cur_q, cur_d;
  logic [DepW-1:0]       depth_q, depth_d;
  logic [LeafW-1:0]      leaf_q, leaf_d;
  logic                  err_q, err_d;
  logic signed [31:0]    px_q, py_q;
  logic                  out_valid_q, out_valid_d;
  logic [LeafW-1:0]      out_leaf_q;
  logic                  out_err_q;

  line_t  line_mem [MAX_NODES];
  child_t child_mem [MAX_NODES];
  line_t  line_rd_q;
  child_t child_rd_q;

  logic            in_acc;
  logic            wr_en;
  logic [15:0]     wr_idx;
  logic            cur_ok;
  logic            side;
  logic [LinkW-1:0] next_link;
  logic            out_load;
  side_ctl_t       side_ctl;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[ApbAw-1:2] == REG_NODE_COUNT)
                ? ApbDw'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= '0;
    end else if (psel && penable && pwrite && (paddr[ApbAw-1:2] == REG_NODE_COUNT)) begin
      node_count_q <= pwdata[NodeCountW-1:0];
    end
  end

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign wr_idx     = {4'h0, in_i.node_index};
  assign wr_en      = in_acc && (in_i.func == FUNC_WRITE) && (wr_idx < MaxNodesW);

  // Node memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      line_mem[wr_idx[IdxW-1:0]]  <= '{x: in_i.line_x, y: in_i.line_y,
                                      dx: in_i.line_dx, dy: in_i.line_dy};
      child_mem[wr_idx[IdxW-1:0]] <= '{c1: in_i.child_one, c0: in_i.child_zero};
    end
    if (state_q == S_READ) begin
      line_rd_q  <= line_mem[cur_q[IdxW-1:0]];
      child_rd_q <= child_mem[cur_q[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px_q <= in_i.point_x;
      py_q <= in_i.point_y;
    end
  end

  assign side_ctl.load_off = (state_q == S_OFFSET);
  assign side_ctl.mul_en   = (state_q == S_MUL_L) || (state_q == S_MUL_R);
  assign side_ctl.mul_rhs  = (state_q == S_MUL_R);

  bsp_pl_side u_side (
    .clk_i     (clk_i),
    .ctl_i     (side_ctl),
    .point_x_i (px_q),
    .point_y_i (py_q),
    .line_i    (line_rd_q),
    .side_o    (side)
  );

  assign cur_ok    = ({1'b0, cur_q} < {3'b000, node_count_q}) && ({1'b0, cur_q} < MaxNodesW);
  assign next_link = side ? child_rd_q.c1 : child_rd_q.c0;
  assign out_load  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    cur_d   = cur_q;
    depth_d = depth_q;
    leaf_d  = leaf_q;
    err_d   = err_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.func == FUNC_LOCATE)) begin
          cur_d   = {2'b00, node_count_q - NodeCountW'(1)};
          depth_d = '0;
          leaf_d  = '0;
          err_d   = 1'b0;
          state_d = (node_count_q == '0) ? S_DONE : S_READ;
        end
      end
      S_READ: begin
        if (!cur_ok || (depth_q == MaxDepthW)) begin
          err_d   = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_OFFSET;
        end
      end
      S_OFFSET: state_d = S_MUL_L;
      S_MUL_L:  state_d = S_MUL_R;
      S_MUL_R:  state_d = S_DECIDE;
      S_DECIDE: begin
        depth_d = depth_q + DepW'(1);
        if (next_link[LinkW-1]) begin
          leaf_d  = next_link[LeafW-1:0];
          state_d = S_DONE;
        end else begin
          cur_d   = next_link[LeafW-1:0];
          state_d = S_READ;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cur_q   <= '0;
      depth_q <= '0;
      leaf_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      depth_q <= depth_d;
      leaf_q  <= leaf_d;
      err_q   <= err_d;
    end
  end

  // Output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_leaf_q <= err_q ? '0 : leaf_q;
      out_err_q  <= err_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.leaf_index = out_leaf_q;
  assign out_o.walk_error = out_err_q;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import bsp_pl_pkg::*;

  localparam int unsigned MaxNodes      = 4096;
  localparam int unsigned MaxDepth      = 64;
  localparam int unsigned HoldCycles    = 600;
  localparam int unsigned DrainCycles   = 5 * MaxDepth + 16;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned RandomItems   = 1300;
  localparam logic [LinkW-1:0] LeafFlag = 16'h8000;
  localparam logic [ApbAw-1:0] NodeCountAddr = {REG_NODE_COUNT, 2'b00};

  typedef struct {
    logic               func;
    logic [11:0]        idx;
    line_t              ln;
    child_t             links;
    logic signed [31:0] px;
    logic signed [31:0] py;
  } word_t;

  typedef struct {
    logic [LeafW-1:0] leaf;
    logic             err;
  } answer_t;

  logic             clk_i;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [ApbAw-1:0] paddr;
  logic [ApbDw-1:0] pwdata;
  logic [ApbDw-1:0] prdata;
  logic             pready;

  bsp_pl_in_if  in_if ();
  bsp_pl_out_if out_if ();

  bsp_point_location_core #(
    .MAX_NODES(MaxNodes),
    .MAX_DEPTH(MaxDepth)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow of the node store and the node_count register
  line_t                 node_lines  [MaxNodes];
  child_t                node_links  [MaxNodes];
  bit                    node_loaded [MaxNodes];
  logic [NodeCountW-1:0] tree_size;

  answer_t     leaf_q[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned writes_sent;
  int unsigned locates_sent;
  int unsigned failed_walks;
  int unsigned results_seen;
  int unsigned settings_used;
  int unsigned quiet_cycles = 0;
  bit          steady;
  bit          hold_req;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // Walk the shadow tree; returns 0 when the walk would touch an unwritten entry
  function automatic bit locate_leaf(input logic signed [31:0] px, input logic signed [31:0] py,
                                     output answer_t ans);
    int unsigned      cur;
    longint           ox;
    longint           oy;
    logic [LinkW-1:0] link;
    line_t            ln;
    ans.leaf = '0;
    ans.err  = 1'b0;
    if (tree_size == 0) return 1'b1;
    cur = tree_size - 1;
    ans.err = 1'b1;
    for (int unsigned depth = 0; depth < MaxDepth; depth++) begin
      if (cur >= tree_size || cur >= MaxNodes) break;
      if (!node_loaded[cur]) return 1'b0;
      ln = node_lines[cur];
      ox = longint'(px) - longint'($signed(ln.x)) * 65536;
      oy = longint'(py) - longint'($signed(ln.y)) * 65536;
      // strict test: equal products fall to child 1
      if (longint'($signed(ln.dx)) * oy < longint'($signed(ln.dy)) * ox)
        link = node_links[cur].c0;
      else
        link = node_links[cur].c1;
      if (link[LinkW-1]) begin
        ans.leaf = link[LeafW-1:0];
        ans.err  = 1'b0;
        break;
      end
      cur = link;
    end
    if (ans.err) ans.leaf = '0;
    return 1'b1;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] rand_coord();
    int v;
    if ($urandom_range(0, 1) == 1) return 16'($urandom);
    v = int'($urandom_range(0, 1024)) - 512;
    return 16'(v);
  endfunction

  function automatic logic [15:0] rand_dir();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'h8000;
    if (r == 2) return 16'h7FFF;
    return rand_coord();
  endfunction

  function automatic logic [31:0] rand_point();
    int whole;
    if ($urandom_range(0, 1) == 1) return $urandom;
    whole = int'($urandom_range(0, 1200)) - 600;
    return {16'(whole), 16'($urandom)};
  endfunction

  function automatic line_t rand_line();
    line_t ln;
    ln.x  = rand_coord();
    ln.y  = rand_coord();
    ln.dx = rand_dir();
    ln.dy = rand_dir();
    return ln;
  endfunction

  // Child link for node at within the written span [base, n)
  function automatic logic [LinkW-1:0] rand_link(input int unsigned at, input int unsigned base,
                                                 input int unsigned n);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40 || (r < 85 && at == base)) return LeafFlag | 16'($urandom_range(0, 32767));
    if (r < 85) return 16'($urandom_range(base, at - 1));
    if (r < 93) return 16'($urandom_range(n, 32767));
    return 16'($urandom_range(at, n - 1));
  endfunction

  task automatic send_word(input word_t w);
    answer_t     ans;
    int unsigned gap;
    if (w.func == FUNC_LOCATE && !locate_leaf(w.px, w.py, ans)) return;
    @(negedge clk_i);
    in_if.valid      <= 1'b1;
    in_if.func       <= w.func;
    in_if.node_index <= w.idx;
    in_if.line_x     <= w.ln.x;
    in_if.line_y     <= w.ln.y;
    in_if.line_dx    <= w.ln.dx;
    in_if.line_dy    <= w.ln.dy;
    in_if.child_zero <= w.links.c0;
    in_if.child_one  <= w.links.c1;
    in_if.point_x    <= w.px;
    in_if.point_y    <= w.py;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    if (w.func == FUNC_WRITE) begin
      node_lines[w.idx]  = w.ln;
      node_links[w.idx]  = w.links;
      node_loaded[w.idx] = 1'b1;
      writes_sent++;
    end else begin
      leaf_q.insert(leaf_q.size(), ans);
      locates_sent++;
      if (ans.err) failed_walks++;
    end
    gap = pick_gap();
    if (gap != 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic write_node(input int unsigned at, input line_t ln, input logic [LinkW-1:0] c0,
                            input logic [LinkW-1:0] c1);
    word_t w;
    w.func     = FUNC_WRITE;
    w.idx      = 12'(at);
    w.ln       = ln;
    w.links.c0 = c0;
    w.links.c1 = c1;
    w.px       = $urandom;
    w.py       = $urandom;
    send_word(w);
  endtask

  task automatic locate_point(input logic signed [31:0] px, input logic signed [31:0] py);
    word_t w;
    w.func     = FUNC_LOCATE;
    w.idx      = 12'($urandom);
    w.ln       = rand_line();
    w.links.c0 = 16'($urandom);
    w.links.c1 = 16'($urandom);
    w.px       = px;
    w.py       = py;
    send_word(w);
  endtask

  // Drop valid and hold until every pending result is back
  task automatic wait_idle();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (leaf_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAw-1:0] addr, input logic [ApbDw-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic apb_read(input logic [ApbAw-1:0] addr, output logic [ApbDw-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_node_count(input int unsigned n);
    logic [ApbDw-1:0] rd;
    wait_idle();
    apb_write(NodeCountAddr, ApbDw'(n));
    tree_size = NodeCountW'(n);
    settings_used++;
    apb_read(NodeCountAddr, rd);
    if (rd[NodeCountW-1:0] !== tree_size)
      report_mismatch($sformatf("node_count reads %0d, wrote %0d", rd[NodeCountW-1:0], n));
  endtask

  task automatic test_empty_tree();
    set_node_count(0);
    locate_point(32'sh0, 32'sh0);
    locate_point(32'sh7FFFFFFF, 32'sh80000000);
    locate_point(32'sh80000000, 32'sh7FFFFFFF);
  endtask

  task automatic test_side_extremes();
    line_t ln;
    ln = '{x: 16'sh7FFF, y: 16'sh8000, dx: 16'sh8000, dy: 16'sh7FFF};
    write_node(0, ln, LeafFlag, 16'hFFFF);
    set_node_count(1);
    locate_point(32'sh7FFFFFFF, 32'sh80000000);
    locate_point(32'sh80000000, 32'sh7FFFFFFF);
    // point on the line origin: both products are zero
    locate_point({16'h7FFF, 16'h0000}, {16'h8000, 16'h0000});
    locate_point(32'sh0, 32'sh0);
    ln = '{x: 16'sh8000, y: 16'sh7FFF, dx: 16'sh7FFF, dy: 16'sh8000};
    write_node(0, ln, LeafFlag | 16'h0001, LeafFlag | 16'h7FFE);
    locate_point(32'sh7FFFFFFF, 32'sh7FFFFFFF);
    locate_point(32'sh80000000, 32'sh80000000);
    // degenerate line with zero direction
    ln = '{x: 16'sh0000, y: 16'sh0000, dx: 16'sh0000, dy: 16'sh0000};
    write_node(0, ln, LeafFlag | 16'h0123, LeafFlag | 16'h0456);
    locate_point(rand_point(), rand_point());
  endtask

  task automatic test_walk_errors();
    line_t ln;
    ln = '{x: 16'sh0000, y: 16'sh0000, dx: 16'sh0001, dy: 16'sh0000};
    // node 1 loops on itself, root sends its upper side past node_count
    write_node(1, ln, 16'h0001, 16'h0001);
    write_node(2, ln, 16'h0001, 16'h0005);
    set_node_count(3);
    locate_point(32'sh0, -32'sh1);
    locate_point(32'sh0, 32'sh10000);
    write_node(2, ln, 16'h0001, 16'h7FFF);
    locate_point(32'sh0, 32'sh10000);
  endtask

  task automatic test_depth_bound();
    line_t ln;
    ln = '{x: 16'sh0000, y: 16'sh0000, dx: 16'sh0001, dy: 16'sh0000};
    for (int unsigned i = 0; i <= MaxDepth; i++)
      write_node(i, ln, (i == 0) ? (LeafFlag | 16'h0007) : 16'(i - 1), LeafFlag | 16'(i));
    // MaxDepth nodes reach the leaf on the last read
    set_node_count(MaxDepth);
    locate_point(32'sh0, -32'sh1);
    locate_point(32'sh0, 32'sh5);
    // one node more runs out of depth
    set_node_count(MaxDepth + 1);
    locate_point(32'sh0, -32'sh1);
    locate_point(32'sh0, 32'sh0);
  endtask

  task automatic test_backpressure();
    steady   = 1'b1;
    hold_req = 1'b1;
    repeat (24) locate_point(32'($urandom_range(0, 1)) - 32'sh1, rand_point());
    steady = 1'b0;
    wait_idle();
  endtask

  task automatic test_random_trees();
    int unsigned start;
    int unsigned phase;
    int unsigned n;
    int unsigned k;
    int unsigned base;
    int unsigned r;
    start = items_sent;
    phase = 0;
    while (items_sent - start < RandomItems) begin
      case (phase)
        0: n = MaxNodes;
        1: n = 1;
        2: n = 0;
        3: n = MaxNodes - 1;
        default: begin
          r = $urandom_range(0, 99);
          if (r < 70) n = $urandom_range(2, 40);
          else if (r < 90) n = $urandom_range(41, MaxNodes);
          else n = $urandom_range(0, 1);
        end
      endcase
      steady = ($urandom_range(0, 3) == 0);
      set_node_count(n);
      k = $urandom_range(1, 20);
      if (k > n) k = n;
      base = n - k;
      for (int unsigned i = base; i < n; i++)
        write_node(i, rand_line(), rand_link(i, base, n), rand_link(i, base, n));
      repeat ($urandom_range(15, 50)) begin
        if ($urandom_range(0, 9) == 0)
          write_node($urandom_range(0, MaxNodes - 1), rand_line(), 16'($urandom), 16'($urandom));
        locate_point(rand_point(), rand_point());
      end
      phase++;
    end
    steady = 1'b0;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        stall_left = HoldCycles;
        hold_req   = 1'b0;
      end else if (stall_left == 0 && !steady && $urandom_range(0, 99) < 20) begin
        stall_left = pick_stall();
      end
      if (stall_left != 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (leaf_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: leaf %0d err %0b",
                                  out_if.leaf_index, out_if.walk_error));
      end else begin
        want = leaf_q.pop_front();
        results_seen++;
        if (out_if.leaf_index !== want.leaf)
          report_mismatch($sformatf("leaf_index %0d, want %0d", out_if.leaf_index, want.leaf));
        if (out_if.walk_error !== want.err)
          report_mismatch($sformatf("walk_error %0b, want %0b", out_if.walk_error, want.err));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("[bsp_point_location_core] ERROR");
      $finish;
    end
  end

  initial begin
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_if.valid      = 1'b0;
    in_if.func       = FUNC_WRITE;
    in_if.node_index = '0;
    in_if.line_x     = '0;
    in_if.line_y     = '0;
    in_if.line_dx    = '0;
    in_if.line_dy    = '0;
    in_if.child_zero = '0;
    in_if.child_one  = '0;
    in_if.point_x    = '0;
    in_if.point_y    = '0;
    tree_size        = '0;
    steady           = 1'b0;
    hold_req         = 1'b0;
    mismatches       = 0;
    items_sent       = 0;
    writes_sent      = 0;
    locates_sent     = 0;
    failed_walks     = 0;
    results_seen     = 0;
    settings_used    = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_tree();
    test_side_extremes();
    test_walk_errors();
    test_depth_bound();
    test_backpressure();
    test_random_trees();

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (leaf_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", leaf_q.size()));

    $display("covered %0d node writes and %0d point queries (%0d failing walks)",
             writes_sent, locates_sent, failed_walks);
    $display("node_count set %0d times, %0d results checked, %0d mismatches",
             settings_used, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("[bsp_point_location_core] OK");
    end else begin
      $display("[bsp_point_location_core] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
design/bsp_pl_pkg.sv
design/bsp_pl_if.sv
design/bsp_pl_side.sv
design/bsp_point_location_core.sv
sim/tb_top.sv
